// ===== rtl/hhfe_pkg.sv =====
// Shared types, codes and constants for the HTTP header field extractor.
package hhfe_pkg;

    localparam int unsigned MAX_NAME_BYTES = 16;
    localparam int unsigned NAME_POS_W     = 5;
    localparam int unsigned COUNT_W        = 10;
    localparam int unsigned CFG_DATA_W     = 64;
    localparam int unsigned CFG_INDEX_W    = 2;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_LOW   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_HIGH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_LEN   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VALUE_CAP  = 2'd3;

    localparam logic [NAME_POS_W-1:0] NAME_LEN_RESET  = 5'd1;
    localparam logic [COUNT_W-1:0]    VALUE_CAP_RESET = 10'd300;

    // action codes
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    // line phases
    localparam logic [1:0] PH_NAME    = 2'd0;
    localparam logic [1:0] PH_VALUE   = 2'd1;
    localparam logic [1:0] PH_SKIP_CR = 2'd2;
    localparam logic [1:0] PH_SKIP_LF = 2'd3;

    typedef struct packed {
        logic [63:0]           name_low;
        logic [63:0]           name_high;
        logic [NAME_POS_W-1:0] name_length;
        logic [COUNT_W-1:0]    value_capacity;
    } cfg_t;

    typedef struct packed {
        logic               value_valid;
        logic [7:0]         value_byte;
        logic [COUNT_W-1:0] value_count;
        logic               done_res;
        logic               matched;
    } result_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== rtl/http_header_field_extractor_top.sv =====
// Top level of the HTTP header field extractor: handshake, config and result registers.
// Path: an accepted input word goes into the input register, then through the step logic into
//   the result register, where the result word is held until it is taken.
// Throughput: one word per cycle while m_ready stays high; the line state is updated once per word.
// Reset (aresetn low, synchronous): both stages empty, line state cleared, name registers
//   zero, name length 1, value capacity 300. No clearing pass; ready the cycle after.
module http_header_field_extractor_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [hhfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hhfe_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // input words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [7:0]                          s_data_byte,
    // result words
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_value_valid,
    output logic [7:0]                          m_value_byte,
    output logic [hhfe_pkg::COUNT_W-1:0]        m_value_count,
    output logic                                m_done_res,
    output logic                                m_matched
);
    import hhfe_pkg::*;

    // configuration registers
    cfg_t    cfg_reg;

    // input stage
    logic       in_valid_reg;
    logic       in_action_reg;
    logic [7:0] in_byte_reg;

    // result stage
    logic    out_valid_reg;
    result_t out_reg;
    result_t step_result;

    logic advance;
    logic step_en;

    // The result stage moves when empty or being drained; the input stage
    // refills whenever it empties into the result stage.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign step_en = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.name_low       <= '0;
            cfg_reg.name_high      <= '0;
            cfg_reg.name_length    <= NAME_LEN_RESET;
            cfg_reg.value_capacity <= VALUE_CAP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_NAME_LOW:  cfg_reg.name_low       <= cfg_wr_data;
                REG_NAME_HIGH: cfg_reg.name_high      <= cfg_wr_data;
                REG_NAME_LEN:  cfg_reg.name_length    <= cfg_wr_data[NAME_POS_W-1:0];
                REG_VALUE_CAP: cfg_reg.value_capacity <= cfg_wr_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_byte_reg   <= s_data_byte;
        end
        if (step_en) begin
            out_reg <= step_result;
        end
    end

    hhfe_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .action    (in_action_reg),
        .data_byte (in_byte_reg),
        .cfg       (cfg_reg),
        .result    (step_result)
    );

    assign m_valid       = out_valid_reg;
    assign m_value_valid = out_reg.value_valid;
    assign m_value_byte  = out_reg.value_byte;
    assign m_value_count = out_reg.value_count;
    assign m_done_res    = out_reg.done_res;
    assign m_matched     = out_reg.matched;

endmodule

// ===== rtl/hhfe_core.sv =====
// Line state and per-word step logic of the header field extractor.
module hhfe_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  logic                  action,
    input  logic [7:0]            data_byte,
    input  hhfe_pkg::cfg_t        cfg,
    output hhfe_pkg::result_t     result
);
    import hhfe_pkg::*;

    logic [1:0]            phase_reg, phase_next;
    logic [NAME_POS_W-1:0] name_pos_reg, name_pos_next;
    logic                  delim_reg, delim_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  finished_reg, finished_next;
    logic                  found_reg, found_next;

    logic [127:0]          name_all;
    logic [3:0]            pos;
    logic [7:0]            name_byte;
    logic [NAME_POS_W-1:0] eff_len;
    logic [NAME_POS_W-1:0] pos_inc;
    logic [COUNT_W:0]      count_inc;
    logic                  cap_ok;
    logic                  vvalid;
    logic [7:0]            vbyte;

    assign name_all  = {cfg.name_high, cfg.name_low};
    assign pos       = name_pos_reg[3:0];
    assign name_byte = name_all[{pos, 3'b000} +: 8];
    assign pos_inc   = {1'b0, pos} + NAME_POS_W'(1);
    assign count_inc = {1'b0, count_reg} + (COUNT_W+1)'(1);
    assign cap_ok    = count_inc <= {1'b0, cfg.value_capacity};

    always_comb begin
        if (cfg.name_length == '0) begin
            eff_len = NAME_POS_W'(1);
        end else if (cfg.name_length > NAME_POS_W'(MAX_NAME_BYTES)) begin
            eff_len = NAME_POS_W'(MAX_NAME_BYTES);
        end else begin
            eff_len = cfg.name_length;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        name_pos_next = name_pos_reg;
        delim_next    = delim_reg;
        count_next    = count_reg;
        finished_next = finished_reg;
        found_next    = found_reg;
        vvalid        = 1'b0;
        vbyte         = 8'h00;
        if (action == ACT_RESTART) begin
            phase_next    = PH_NAME;
            name_pos_next = '0;
            delim_next    = 1'b0;
            count_next    = '0;
            finished_next = 1'b0;
            found_next    = 1'b0;
        end else if (!finished_reg) begin
            case (phase_reg)
                PH_NAME: begin
                    if (to_lower(data_byte) != name_byte) begin
                        phase_next = (data_byte == CHAR_CR) ? PH_SKIP_LF : PH_SKIP_CR;
                    end else begin
                        name_pos_next = pos_inc;
                        if (pos_inc >= eff_len) begin
                            phase_next = PH_VALUE;
                        end
                    end
                end
                PH_VALUE: begin
                    if (cap_ok) begin
                        count_next = count_inc[COUNT_W-1:0];
                        vvalid     = 1'b1;
                        vbyte      = data_byte;
                    end
                    if (!delim_reg) begin
                        if (data_byte == CHAR_CR) begin
                            delim_next = 1'b1;
                        end
                    end else if (data_byte == CHAR_LF) begin
                        finished_next = 1'b1;
                        found_next    = 1'b1;
                    end else begin
                        delim_next = 1'b0;
                    end
                end
                PH_SKIP_CR: begin
                    if (data_byte == CHAR_CR) begin
                        phase_next = PH_SKIP_LF;
                    end
                end
                default: begin
                    if (data_byte == CHAR_LF) begin
                        finished_next = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_NAME;
            name_pos_reg <= '0;
            delim_reg    <= 1'b0;
            count_reg    <= '0;
            finished_reg <= 1'b0;
            found_reg    <= 1'b0;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            name_pos_reg <= name_pos_next;
            delim_reg    <= delim_next;
            count_reg    <= count_next;
            finished_reg <= finished_next;
            found_reg    <= found_next;
        end
    end

    assign result.value_valid = vvalid;
    assign result.value_byte  = vbyte;
    assign result.value_count = count_next;
    assign result.done_res    = finished_next;
    assign result.matched     = found_next;

endmodule

// ===== rtl/hhfe_checker.sv =====
// Port-level assertions for the header field extractor, bound to the top level.
module hhfe_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic                             m_value_valid,
    input logic [7:0]                       m_value_byte,
    input logic [hhfe_pkg::COUNT_W-1:0]     m_value_count,
    input logic                             m_done_res,
    input logic                             m_matched
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_valid) && $stable(m_value_byte)
            && $stable(m_value_count) && $stable(m_done_res) && $stable(m_matched))
        else $error("result word changed while stalled");

    // the input only stalls behind a stalled result word
    a_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with the result side free");

    // uncaptured bytes read as zero
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_value_valid |-> m_value_byte == 8'h00)
        else $error("value byte nonzero without value_valid");

    // a match only ever comes with a finished line
    a_match_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_matched |-> m_done_res)
        else $error("matched without done");

    // a captured byte has been counted
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_value_valid |-> m_value_count != '0)
        else $error("captured byte with zero count");

endmodule

bind http_header_field_extractor_top hhfe_checker u_hhfe_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_value_valid (m_value_valid),
    .m_value_byte  (m_value_byte),
    .m_value_count (m_value_count),
    .m_done_res    (m_done_res),
    .m_matched     (m_matched)
);
